[hw/rtl/hklc_pkg.sv]
package hklc_pkg;

    localparam int ENTRIES    = 16;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int KEY_W      = 64;
    localparam int COORD_W    = 16;
    localparam int NUM_COORDS = 4;
    localparam int CNT_W      = 32;

    // 64-bit hash prime = 2^40 + 0x1B3
    localparam int             PRIME_SHIFT = 40;
    localparam int             PRIME_LO_W  = 9;
    localparam logic [PRIME_LO_W-1:0] PRIME_LO = 9'h1B3;

    localparam int FOUND_BIT = KEY_W + NUM_COORDS * COORD_W;
    localparam int S_TDATA_W = ((FOUND_BIT + 1 + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 + 2 * CNT_W + 7) / 8) * 8;
    localparam int CMD_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP      = 2'd0,
        CMD_STORE       = 2'd1,
        CMD_CLEAR       = 2'd2,
        CMD_ZERO_COUNTS = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // top -> table, one-cycle requests
    typedef struct packed {
        logic lookup;
        logic store;
        logic clear;
        logic found;
    } tbl_req_t;

    // table -> top, done pulses once per lookup
    typedef struct packed {
        logic done;
        logic hit;
        logic found;
    } tbl_rsp_t;

endpackage

[hw/rtl/hklc_key_unit.sv]
module hklc_key_unit (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  logic [hklc_pkg::KEY_W-1:0]                        seed,
    input  logic [hklc_pkg::NUM_COORDS*hklc_pkg::COORD_W-1:0] coords,
    output logic [hklc_pkg::KEY_W-1:0]                        key,
    output logic                                              done
);
    import hklc_pkg::*;

    localparam int STEP_W = (NUM_COORDS > 1) ? $clog2(NUM_COORDS) : 1;

    logic [KEY_W-1:0]              key_reg, key_next;
    logic [NUM_COORDS*COORD_W-1:0] coord_reg, coord_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    logic [KEY_W-1:0]            coord_ext;
    logic [KEY_W-1:0]            mix;
    logic [KEY_W+PRIME_LO_W-1:0] mul_lo;
    logic [KEY_W-1:0]            folded;

    // shared fold step: (h ^ sext(c)) * prime, mod 2^64
    always_comb
    begin
        coord_ext = {{(KEY_W-COORD_W){coord_reg[COORD_W-1]}}, coord_reg[COORD_W-1:0]};
        mix       = key_reg ^ coord_ext;
        mul_lo    = mix * PRIME_LO;
        folded    = (mix << PRIME_SHIFT) + mul_lo[KEY_W-1:0];
    end

    always_comb
    begin
        key_next   = key_reg;
        coord_next = coord_reg;
        step_next  = step_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            key_next   = seed;
            coord_next = coords;
            step_next  = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            key_next   = folded;
            coord_next = coord_reg >> COORD_W;
            step_next  = step_reg + 1'b1;
            if (step_reg == STEP_W'(NUM_COORDS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        coord_reg <= coord_next;
    end

    assign key  = key_reg;
    assign done = done_reg;

endmodule

[hw/rtl/hklc_table.sv]
module hklc_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  hklc_pkg::tbl_req_t         req,
    input  logic [hklc_pkg::KEY_W-1:0] key,
    output hklc_pkg::tbl_rsp_t         rsp
);
    import hklc_pkg::*;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] found_reg, found_next;
    logic [KEY_W-1:0]   key_mem [ENTRIES];
    logic [KEY_W-1:0]   key_rd_reg;
    logic [IDX_W-1:0]   rank_reg [ENTRIES];
    logic [IDX_W-1:0]   rank_next [ENTRIES];
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               scanning_reg, scanning_next;
    tbl_rsp_t           rsp_reg, rsp_next;

    logic [IDX_W-1:0] victim;
    logic             have_free;
    logic             match;
    logic             touch_en;
    logic [IDX_W-1:0] touch_idx;
    logic [IDX_W-1:0] touch_rank;

    // victim: lowest free entry, else the one with rank 0
    always_comb
    begin
        victim    = '0;
        have_free = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                victim    = IDX_W'(i);
                have_free = 1'b1;
            end
        end
        if (!have_free)
        begin
            for (int i = ENTRIES - 1; i >= 0; i--)
            begin
                if (rank_reg[i] == '0)
                begin
                    victim = IDX_W'(i);
                end
            end
        end
    end

    assign match = valid_reg[scan_idx_reg] && (key_rd_reg == key);

    always_comb
    begin
        valid_next    = valid_reg;
        found_next    = found_reg;
        scan_idx_next = scan_idx_reg;
        scanning_next = scanning_reg;
        rsp_next      = '0;
        touch_en      = 1'b0;
        touch_idx     = victim;

        if (req.clear)
        begin
            valid_next = '0;
            found_next = '0;
        end
        else if (req.store)
        begin
            valid_next[victim] = 1'b1;
            found_next[victim] = req.found;
            touch_en           = 1'b1;
        end
        else if (req.lookup)
        begin
            scanning_next = 1'b1;
            scan_idx_next = '0;
        end
        else if (scanning_reg)
        begin
            if (match)
            begin
                touch_en      = 1'b1;
                touch_idx     = scan_idx_reg;
                scanning_next = 1'b0;
                rsp_next.done  = 1'b1;
                rsp_next.hit   = 1'b1;
                rsp_next.found = found_reg[scan_idx_reg];
            end
            else if (scan_idx_reg == IDX_W'(ENTRIES - 1))
            begin
                scanning_next = 1'b0;
                rsp_next.done = 1'b1;
            end
            else
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
        end

        // recency: touched entry to top, those above it slide down
        touch_rank = rank_reg[touch_idx];
        for (int j = 0; j < ENTRIES; j++)
        begin
            rank_next[j] = rank_reg[j];
            if (touch_en && (rank_reg[j] > touch_rank))
            begin
                rank_next[j] = rank_reg[j] - 1'b1;
            end
        end
        if (touch_en)
        begin
            rank_next[touch_idx] = IDX_W'(ENTRIES - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            found_reg    <= '0;
            scan_idx_reg <= '0;
            scanning_reg <= 1'b0;
            rsp_reg      <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= IDX_W'(i);
            end
        end
        else
        begin
            valid_reg    <= valid_next;
            found_reg    <= found_next;
            scan_idx_reg <= scan_idx_next;
            scanning_reg <= scanning_next;
            rsp_reg      <= rsp_next;
            rank_reg     <= rank_next;
        end
    end

    // read at the next scan index so the data lines up with scan_idx_reg
    always_ff @(posedge clk)
    begin
        if (req.store)
        begin
            key_mem[victim] <= key;
        end
        key_rd_reg <= key_mem[scan_idx_next];
    end

    assign rsp = rsp_reg;

endmodule

[hw/rtl/hash_keyed_lru_result_cache_core.sv]
// Channel  Dir  Signals                      Content
// s        in   s_tvalid/s_tready/s_tdata    one request, s_tuser = command
// m        out  m_tvalid/m_tready/m_tdata    one result per request
//
// Every request first runs the four fold steps through the shared
// multiply-by-prime unit; a lookup then scans the tags at one entry per
// cycle up to the first hit or the last entry. Reset leaves all entries
// invalid, ranks in index order, counters zero. s_tready is low while a
// request is in work; a stalled result waits in the output register and
// holds back only the next result.
module hash_keyed_lru_result_cache_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // grid_signature, start_x, start_y, end_x, end_y, store_found, zero pad
    input  logic [hklc_pkg::S_TDATA_W-1:0]       s_tdata,
    // command
    input  logic [hklc_pkg::CMD_W-1:0]           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // hit, hit_found, hit_count, miss_count, zero pad
    output logic [hklc_pkg::M_TDATA_W-1:0]       m_tdata
);
    import hklc_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic                   store_found_reg, store_found_next;
    logic                   hit_reg, hit_next;
    logic                   hit_found_reg, hit_found_next;
    logic [CNT_W-1:0]       hits_reg, hits_next;
    logic [CNT_W-1:0]       misses_reg, misses_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic             accept;
    logic [KEY_W-1:0] key;
    logic             key_done;
    tbl_req_t         req;
    tbl_rsp_t         rsp;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    hklc_key_unit u_key (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .seed   (s_tdata[KEY_W-1:0]),
        .coords (s_tdata[KEY_W +: NUM_COORDS*COORD_W]),
        .key    (key),
        .done   (key_done)
    );

    hklc_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .key   (key),
        .rsp   (rsp)
    );

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        store_found_next = store_found_reg;
        hit_next         = hit_reg;
        hit_found_next   = hit_found_reg;
        hits_next        = hits_reg;
        misses_next      = misses_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        req              = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next         = cmd_t'(s_tuser);
                    store_found_next = s_tdata[FOUND_BIT];
                    state_next       = ST_HASH;
                end
            end
            ST_HASH:
            begin
                hit_next       = 1'b0;
                hit_found_next = 1'b0;
                if (key_done)
                begin
                    state_next = ST_RESULT;
                    unique case (cmd_reg)
                        CMD_LOOKUP:
                        begin
                            req.lookup = 1'b1;
                            state_next = ST_SCAN;
                        end
                        CMD_STORE:
                        begin
                            req.store = 1'b1;
                            req.found = store_found_reg;
                        end
                        CMD_CLEAR:
                        begin
                            req.clear = 1'b1;
                        end
                        CMD_ZERO_COUNTS:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (rsp.done)
                begin
                    hit_next       = rsp.hit;
                    hit_found_next = rsp.found;
                    state_next     = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        if (hit_reg)
                        begin
                            if (hits_reg != CNT_MAX)
                            begin
                                hits_next = hits_reg + 1'b1;
                            end
                        end
                        else if (misses_reg != CNT_MAX)
                        begin
                            misses_next = misses_reg + 1'b1;
                        end
                    end
                    else if (cmd_reg == CMD_ZERO_COUNTS)
                    begin
                        hits_next   = '0;
                        misses_next = '0;
                    end
                    m_tdata_next  = M_TDATA_W'({misses_next, hits_next,
                                                hit_found_reg, hit_reg});
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cmd_reg      <= CMD_LOOKUP;
            hits_reg     <= '0;
            misses_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            hits_reg     <= hits_next;
            misses_reg   <= misses_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_found_reg <= store_found_next;
        hit_reg         <= hit_next;
        hit_found_reg   <= hit_found_next;
        m_tdata_reg     <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
